[sv/tefc_pkg.sv]
package tefc_pkg;

  typedef enum logic [2:0] {
    FMT_F16  = 3'd0,
    FMT_BF16 = 3'd1,
    FMT_I32  = 3'd2,
    FMT_I64  = 3'd3,
    FMT_F32  = 3'd4
  } fmt_t;

  localparam int RawW   = 64;
  localparam int FloatW = 32;
  localparam int FmtW   = 3;
  localparam int PosW   = 6;

  // one stage of the pipeline as seen by the next
  typedef struct packed {
    logic              neg;
    logic              is_int;
    logic              zero;
    logic [PosW-1:0]   pos;
    logic [RawW-1:0]   mag;
    logic [FloatW-1:0] direct;
  } stage_t;

endpackage

[sv/tefc_lod.sv]
// leading-one position of a 64-bit magnitude, two-level search
module tefc_lod (
  input  logic [tefc_pkg::RawW-1:0] val,
  output logic [tefc_pkg::PosW-1:0] pos
);
  import tefc_pkg::*;

  logic [7:0] grp_nz;
  logic [2:0] grp;
  logic [2:0] bit_idx;
  logic [7:0] byte_sel;

  // find highest nonzero byte, then highest bit inside it
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_nz[g] = |val[g*8 +: 8];
    end
    grp = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) grp = 3'(g);
    end
    byte_sel = val[grp*8 +: 8];
    bit_idx = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_sel[b]) bit_idx = 3'(b);
    end
    pos = {grp, bit_idx};
  end
endmodule

[sv/tensor_element_to_fp32_converter.sv]
// throughput: one element per cycle; a stall holds all stages in place
// stages: decode and magnitude, leading-one search, normalize and round
// reset: rst clears stage valid bits and sets source_format to f16
module tensor_element_to_fp32_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // raw_element[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // float_bits[31:0]
);
  import tefc_pkg::*;

  logic [FmtW-1:0] source_format;
  logic            v1, v2, v3;
  stage_t          s1, s2;
  logic [FloatW-1:0] res3;
  logic            adv;
  stage_t          s1_next;
  logic [PosW-1:0] lod_pos;
  logic [FloatW-1:0] res_next;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = res3;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_F16;
    end else if (cfg_valid) begin
      source_format <= cfg_data;
    end
  end

  // stage 1 decode: sign, magnitude and direct results
  always_comb begin
    logic [15:0] h;
    logic [31:0] w;
    h = s_axis_tdata[15:0];
    w = s_axis_tdata[31:0];
    s1_next = '0;
    s1_next.direct = w;
    unique case (source_format)
      FMT_F16: begin
        s1_next.neg = h[15];
        s1_next.mag = {54'd0, h[9:0]};
        s1_next.zero = (h[14:10] == 5'd0);
        s1_next.direct = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
        if (h[14:10] == 5'd31) s1_next.direct = {h[15], 8'hFF, h[9:0], 13'd0};
      end
      FMT_BF16: s1_next.direct = {h, 16'd0};
      FMT_I32: begin
        s1_next.is_int = 1'b1;
        s1_next.neg = w[31];
        s1_next.mag = {32'd0, w[31] ? (32'd0 - w) : w};
      end
      FMT_I64: begin
        s1_next.is_int = 1'b1;
        s1_next.neg = s_axis_tdata[63];
        s1_next.mag = s_axis_tdata[63] ? (64'd0 - s_axis_tdata) : s_axis_tdata;
      end
      default: ;
    endcase
  end

  tefc_lod u_lod (.val(s1.mag), .pos(lod_pos));

  // stage 3 normalize and round
  always_comb begin
    logic [127:0] sh;
    logic [23:0]  keep;
    logic         g, st;
    logic [24:0]  kr;
    logic [7:0]   ex;
    // leading one lands on bit 87, top of the kept mantissa
    sh = {64'd0, s2.mag} << (7'd87 - 7'(s2.pos));
    keep = sh[87:64];
    g  = sh[63];
    st = |sh[62:0];
    kr = {1'b0, keep} + 25'(g && (st || keep[0]));
    ex = 8'd127 + 8'(s2.pos);
    if (kr[24]) begin
      ex = ex + 8'd1;
    end
    res_next = s2.direct;
    if (s2.is_int) begin
      res_next = (s2.mag == 64'd0) ? 32'd0
        : {s2.neg, ex, kr[24] ? kr[23:1] : kr[22:0]};
    end else if (s2.zero) begin
      // f16 subnormal or zero
      res_next = {s2.neg, 31'd0};
      if (s2.mag != 64'd0) begin
        res_next = {s2.neg, 8'd103 + 8'(s2.pos),
                    10'(s2.mag[9:0] << (4'd10 - 4'(s2.pos))), 13'd0};
      end
    end
  end

  // pipeline registers with travelling valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= {s1.neg, s1.is_int, s1.zero, lod_pos, s1.mag, s1.direct};
      res3 <= res_next;
    end
  end
endmodule

[sv/tefc_checker.sv]
module tefc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // output held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // input side ready whenever output is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  // output stays invalid when reset has just been released
  a_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
  // accepted input reaches output valid through v1, v2 and v3 while the pipeline keeps advancing
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
      |=> m_axis_tvalid)
    else $error("result lost in pipeline");
endmodule

bind tensor_element_to_fp32_converter tefc_checker u_chk (.*);
